// ----- sv/tcs_pkg.sv -----
// ----------------------------------------------------------------------------
// tcs_pkg: text console shared definitions
// Field widths, character codes, action codes and the control/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcs_pkg;

  localparam int ACT_W  = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int RROW_W = 5;
  localparam int RCOL_W = 7;
  localparam int CELL_W = 16;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUT   = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;        // capture the incoming request
    logic put;          // put character / newline at the cursor
    logic home;         // cursor to row 0, column 0
    logic sweep_start;  // sweep counter to zero
    logic clear_step;   // write one blank cell at the sweep counter
    logic scroll_step;  // read one cell a row below, queue its write
    logic rd_issue;     // read the requested cell
    logic load_out;     // load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_e act;
    logic    will_scroll;
    logic    sweep_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- sv/tcs_ram.sv -----
// ----------------------------------------------------------------------------
// tcs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/tcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcs_ctrl: text console controller
// Sequences one request at a time: capture, execute, sweeps, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output tcs_pkg::cmd_t      cmd_o,
  input  wire tcs_pkg::sts_t sts_i
);

  import tcs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL,
    ST_FLUSH,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   finish;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    finish  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts_i.act)
          ACT_PUT: begin
            cmd_o.put = 1'b1;
            if (sts_i.will_scroll) begin
              cmd_o.sweep_start = 1'b1;
              state_d           = ST_SCROLL;
            end else begin
              finish = 1'b1;
            end
          end
          ACT_CLEAR: begin
            cmd_o.home        = 1'b1;
            cmd_o.sweep_start = 1'b1;
            state_d           = ST_CLEAR;
          end
          ACT_READ: begin
            cmd_o.rd_issue = 1'b1;
            state_d        = ST_READ;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.sweep_last) begin
          finish = 1'b1;
        end
      end
      ST_SCROLL: begin
        cmd_o.scroll_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH, ST_READ, ST_EMIT: begin
        finish = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (finish) begin
      if (out_free) begin
        cmd_o.load_out = 1'b1;
        state_d        = ST_IDLE;
      end else begin
        state_d = ST_EMIT;
      end
    end

    out_valid_d = cmd_o.load_out ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // result register is never overwritten while a result still waits
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a waiting result");

  // an accepted request is executed in the following cycle
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_EXEC))
    else $error("accepted request not executed");

endmodule

`default_nettype wire

// ----- sv/tcs_dp.sv -----
// ----------------------------------------------------------------------------
// tcs_dp: text console datapath
// Screen store, cursor, attribute register, sweep counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tcs_dp #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tcs_pkg::cmd_t                cmd_i,
  output tcs_pkg::sts_t                     sts_o,
  input  wire logic                         cfg_wr_en_i,
  input  wire logic [tcs_pkg::ATTR_W-1:0]   cfg_wr_data_i,
  input  wire logic [tcs_pkg::ACT_W-1:0]    action_i,
  input  wire logic [tcs_pkg::CHAR_W-1:0]   char_code_i,
  input  wire logic [tcs_pkg::RROW_W-1:0]   read_row_i,
  input  wire logic [tcs_pkg::RCOL_W-1:0]   read_col_i,
  output logic      [tcs_pkg::RROW_W-1:0]   cursor_row_out_o,
  output logic      [tcs_pkg::RCOL_W-1:0]   cursor_col_out_o,
  output logic      [tcs_pkg::CELL_W-1:0]   cell_value_o,
  output logic                              scrolled_o
);

  import tcs_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int COPY_N = CELLS - COLUMNS;  // cells moved up by a scroll
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int AW     = $clog2(CELLS);

  logic [ATTR_W-1:0] attr_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic              scr_q;

  action_e           act_q;
  logic [CHAR_W-1:0] ch_q;
  logic [RROW_W-1:0] rrow_q;
  logic [RCOL_W-1:0] rcol_q;

  logic [AW-1:0]     cnt_q;
  logic              pend_q;
  logic [AW-1:0]     pend_addr_q;
  logic              pend_blank_q;

  logic [RROW_W-1:0] row_out_q;
  logic [RCOL_W-1:0] col_out_q;
  logic [CELL_W-1:0] cell_out_q;
  logic              scr_out_q;

  logic              row_last, col_last, is_nl, rd_ok, blank_now;
  logic [AW-1:0]     cur_addr, rd_addr, src_addr;
  logic [CELL_W-1:0] blank_cell, rdata;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata;

  assign row_last   = (row_q == ROW_W'(ROWS - 1));
  assign col_last   = (col_q == COL_W'(COLUMNS - 1));
  assign is_nl      = (ch_q == NEWLINE_CODE);
  assign rd_ok      = (32'(rrow_q) < ROWS) && (32'(rcol_q) < COLUMNS);
  assign blank_now  = (32'(cnt_q) >= COPY_N);
  assign cur_addr   = AW'(32'(row_q) * COLUMNS + 32'(col_q));
  assign rd_addr    = AW'(32'(rrow_q) * COLUMNS + 32'(rcol_q));
  assign src_addr   = AW'(32'(cnt_q) + COLUMNS);
  assign blank_cell = {attr_q, SPACE_CODE};

  assign sts_o.act         = act_q;
  assign sts_o.will_scroll = (act_q == ACT_PUT) && (is_nl || col_last) && row_last;
  assign sts_o.sweep_last  = (cnt_q == AW'(CELLS - 1));

  // next cursor; also what a result loaded in the same cycle reports
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cmd_i.home) begin
      row_d = '0;
      col_d = '0;
    end else if (cmd_i.put) begin
      if (is_nl || col_last) begin
        col_d = '0;
        if (!row_last) begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // write port: queued scroll copy, clear sweep, or character put
  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {attr_q, ch_q};
    if (pend_q) begin
      we    = 1'b1;
      waddr = pend_addr_q;
      wdata = pend_blank_q ? blank_cell : rdata;
    end else if (cmd_i.clear_step) begin
      we    = 1'b1;
      waddr = cnt_q;
      wdata = blank_cell;
    end else if (cmd_i.put && !is_nl) begin
      we    = 1'b1;
    end
  end

  assign re    = (cmd_i.rd_issue && rd_ok) || (cmd_i.scroll_step && !blank_now);
  assign raddr = cmd_i.scroll_step ? src_addr : rd_addr;

  tcs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
      row_q  <= '0;
      col_q  <= '0;
      scr_q  <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        attr_q <= cfg_wr_data_i;
      end
      row_q <= row_d;
      col_q <= col_d;
      if (cmd_i.latch) begin
        scr_q <= 1'b0;
      end else if (cmd_i.put && sts_o.will_scroll) begin
        scr_q <= 1'b1;
      end
      pend_q <= cmd_i.scroll_step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      act_q  <= action_e'(action_i);
      ch_q   <= char_code_i;
      rrow_q <= read_row_i;
      rcol_q <= read_col_i;
    end
    if (cmd_i.sweep_start) begin
      cnt_q <= '0;
    end else if (cmd_i.clear_step || cmd_i.scroll_step) begin
      cnt_q <= cnt_q + 1'b1;
    end
    pend_addr_q  <= cnt_q;
    pend_blank_q <= blank_now;
    if (cmd_i.load_out) begin
      row_out_q  <= RROW_W'(row_d);
      col_out_q  <= RCOL_W'(col_d);
      cell_out_q <= ((act_q == ACT_READ) && rd_ok) ? rdata : '0;
      scr_out_q  <= scr_q;
    end
  end

  assign cursor_row_out_o = row_out_q;
  assign cursor_col_out_o = col_out_q;
  assign cell_value_o     = cell_out_q;
  assign scrolled_o       = scr_out_q;

  // queued scroll write never meets another writer
  a_wr_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (!cmd_i.clear_step && !cmd_i.put))
    else $error("write port clash");

  // cursor always inside the screen
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < ROWS) && (32'(col_q) < COLUMNS))
    else $error("cursor out of range");

endmodule

`default_nettype wire

// ----- sv/text_console_cursor_scroll_core.sv -----
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core: character-cell text console
// Screen store of ROWS x COLUMNS cells (attribute high byte, character low
// byte) with a cursor; put, clear and read requests, one result each.
//
// Requests enter on in_valid_i/in_stall_o and are taken one at a time; each
// gives one result on out_valid_o/out_stall_i, held in an output register.
// Attribute is written through cfg_wr_en_i/cfg_wr_data_i; the user must
// write it only while idle, and the block itself does not enforce this.
// A read request goes through a registered RAM read.
// Clear and scroll sweep the screen RAM one cell per cycle through its single
// write port; a scroll copy reads one row ahead and writes in the next cycle.
// The result register loads at the edge that ends the last work cycle.
// Reset: cursor homed, attribute 7, no result pending. The screen RAM is not
// cleared by reset; cells are meaningful only after a clear request.
// If the receiver stalls, the result holds and the next request waits until
// its own result can be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll_core #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration
  input  wire logic                        cfg_wr_en_i,
  input  wire logic [tcs_pkg::ATTR_W-1:0]  cfg_wr_data_i,
  // request channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [tcs_pkg::ACT_W-1:0]   action_i,
  input  wire logic [tcs_pkg::CHAR_W-1:0]  char_code_i,
  input  wire logic [tcs_pkg::RROW_W-1:0]  read_row_i,
  input  wire logic [tcs_pkg::RCOL_W-1:0]  read_col_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [tcs_pkg::RROW_W-1:0]  cursor_row_out_o,
  output logic      [tcs_pkg::RCOL_W-1:0]  cursor_col_out_o,
  output logic      [tcs_pkg::CELL_W-1:0]  cell_value_o,
  output logic                             scrolled_o
);

  import tcs_pkg::*;

  cmd_t cmd;  // controller commands
  sts_t sts;  // datapath status

  // sequencing and handshakes
  tcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // screen store, cursor and result payload
  tcs_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_wr_en_i      (cfg_wr_en_i),
    .cfg_wr_data_i    (cfg_wr_data_i),
    .action_i         (action_i),
    .char_code_i      (char_code_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .cursor_row_out_o (cursor_row_out_o),
    .cursor_col_out_o (cursor_col_out_o),
    .cell_value_o     (cell_value_o),
    .scrolled_o       (scrolled_o)
  );

endmodule

`default_nettype wire
